### rtl/scr_pkg.sv
// Types, constants and tables for the SCSI command responder.
// Holds the microcode program, command classes and fixed response data.
// Depends on nothing.
package scr_pkg;

   localparam int SECTOR_SHIFT = 9;

   localparam logic [7:0] OPC_TEST_READY = 8'h00;
   localparam logic [7:0] OPC_SENSE      = 8'h03;
   localparam logic [7:0] OPC_INQUIRY    = 8'h12;
   localparam logic [7:0] OPC_MODE6      = 8'h1A;
   localparam logic [7:0] OPC_REMOVAL    = 8'h1E;
   localparam logic [7:0] OPC_RFC        = 8'h23;
   localparam logic [7:0] OPC_RCAP       = 8'h25;
   localparam logic [7:0] OPC_READ10     = 8'h28;
   localparam logic [7:0] OPC_WRITE10    = 8'h2A;
   localparam logic [7:0] OPC_VERIFY10   = 8'h2F;
   localparam logic [7:0] OPC_MODE10     = 8'h5A;

   typedef enum logic [3:0] {
      CLS_INQUIRY,
      CLS_SENSE,
      CLS_MODE6,
      CLS_MODE10,
      CLS_RFC,
      CLS_RCAP,
      CLS_NOP,
      CLS_READ,
      CLS_WRITE,
      CLS_VERIFY,
      CLS_UNKNOWN
   } cls_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_DECODE,
      OP_ROOM,
      OP_CLAMP,
      OP_ENDCHK,
      OP_WRSZ,
      OP_RESID,
      OP_EMIT_RUN,
      OP_EMIT_ONE
   } ctl_op_type;

   typedef enum logic [2:0] {
      JMP_WAIT_REQ,
      JMP_NEXT,
      JMP_GOTO,
      JMP_DISPATCH,
      JMP_RUN,
      JMP_EMIT
   } jmp_type;

   typedef logic [3:0] step_type;

   localparam step_type STEP_IDLE   = 4'd0;
   localparam step_type STEP_DECODE = 4'd1;
   localparam step_type STEP_RUN    = 4'd2;
   localparam step_type STEP_ROOM   = 4'd3;
   localparam step_type STEP_CLAMP  = 4'd4;
   localparam step_type STEP_ENDCHK = 4'd5;
   localparam step_type STEP_WRSZ   = 4'd6;
   localparam step_type STEP_RESID  = 4'd7;
   localparam step_type STEP_EMIT   = 4'd8;

   typedef struct packed {
      ctl_op_type op;
      jmp_type    jmp;
      step_type   target;
   } ctl_word_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        data_valid;
      logic        last;
      logic        accepted;
      logic        stall_in;
      logic        stall_out;
      logic        send_status;
      kind_type    transfer_kind;
      logic [40:0] start_offset;
      logic [24:0] transfer_bytes;
      logic [31:0] residue;
   } rsp_word_type;

   localparam logic [7:0] INQUIRY_DATA [36] = '{
      8'h00, 8'h80, 8'h00, 8'h01, 8'h20, 8'h80, 8'h00, 8'h00,
      8'h46, 8'h44, 8'h49, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
      8'h75, 8'h45, 8'h5A, 8'h20, 8'h4D, 8'h53, 8'h20, 8'h44,
      8'h69, 8'h73, 8'h6B, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
      8'h31, 8'h2E, 8'h30, 8'h20
   };

   localparam logic [7:0] SENSE_DATA [18] = '{
      8'h70, 8'h00, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0A, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0] MODE6_DATA [4]  = '{8'h03, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] MODE10_DATA [8] = '{
      8'h00, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   function automatic ctl_word_type ucode(input step_type step);
      ctl_word_type cw;
      cw = '{op: OP_NONE, jmp: JMP_GOTO, target: STEP_IDLE};
      unique case (step)
         STEP_IDLE:   cw = '{op: OP_NONE,     jmp: JMP_WAIT_REQ, target: STEP_DECODE};
         STEP_DECODE: cw = '{op: OP_DECODE,   jmp: JMP_DISPATCH, target: STEP_RUN};
         STEP_RUN:    cw = '{op: OP_EMIT_RUN, jmp: JMP_RUN,      target: STEP_IDLE};
         STEP_ROOM:   cw = '{op: OP_ROOM,     jmp: JMP_NEXT,     target: STEP_CLAMP};
         STEP_CLAMP:  cw = '{op: OP_CLAMP,    jmp: JMP_GOTO,     target: STEP_RESID};
         STEP_ENDCHK: cw = '{op: OP_ENDCHK,   jmp: JMP_NEXT,     target: STEP_WRSZ};
         STEP_WRSZ:   cw = '{op: OP_WRSZ,     jmp: JMP_NEXT,     target: STEP_RESID};
         STEP_RESID:  cw = '{op: OP_RESID,    jmp: JMP_NEXT,     target: STEP_EMIT};
         STEP_EMIT:   cw = '{op: OP_EMIT_ONE, jmp: JMP_EMIT,     target: STEP_IDLE};
         default:     cw = '{op: OP_NONE,     jmp: JMP_GOTO,     target: STEP_IDLE};
      endcase
      return cw;
   endfunction

   function automatic cls_type cmd_class(input logic [7:0] cmd);
      cls_type cls;
      unique case (cmd)
         OPC_INQUIRY:    cls = CLS_INQUIRY;
         OPC_SENSE:      cls = CLS_SENSE;
         OPC_MODE6:      cls = CLS_MODE6;
         OPC_MODE10:     cls = CLS_MODE10;
         OPC_RFC:        cls = CLS_RFC;
         OPC_RCAP:       cls = CLS_RCAP;
         OPC_TEST_READY: cls = CLS_NOP;
         OPC_REMOVAL:    cls = CLS_NOP;
         OPC_READ10:     cls = CLS_READ;
         OPC_WRITE10:    cls = CLS_WRITE;
         OPC_VERIFY10:   cls = CLS_VERIFY;
         default:        cls = CLS_UNKNOWN;
      endcase
      return cls;
   endfunction

   function automatic logic [5:0] run_len(input cls_type cls);
      logic [5:0] n;
      unique case (cls)
         CLS_INQUIRY: n = 6'd36;
         CLS_SENSE:   n = 6'd18;
         CLS_MODE6:   n = 6'd4;
         CLS_MODE10:  n = 6'd8;
         CLS_RFC:     n = 6'd12;
         CLS_RCAP:    n = 6'd8;
         default:     n = 6'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] run_byte(input cls_type cls, input logic [5:0] idx,
                                           input logic [31:0] sectors);
      logic [31:0] last_lba;
      logic [7:0]  b;
      last_lba = sectors - 32'd1;
      b = 8'h00;
      unique case (cls)
         CLS_INQUIRY: b = INQUIRY_DATA[idx];
         CLS_SENSE:   b = SENSE_DATA[idx[4:0]];
         CLS_MODE6:   b = MODE6_DATA[idx[1:0]];
         CLS_MODE10:  b = MODE10_DATA[idx[2:0]];
         CLS_RFC: begin
            unique case (idx[3:0])
               4'd3:    b = 8'h08;
               4'd4:    b = sectors[31:24];
               4'd5:    b = sectors[23:16];
               4'd6:    b = sectors[15:8];
               4'd7:    b = sectors[7:0];
               4'd8:    b = 8'h02;
               4'd10:   b = 8'h02;
               default: b = 8'h00;
            endcase
         end
         CLS_RCAP: begin
            unique case (idx[2:0])
               3'd0:    b = last_lba[31:24];
               3'd1:    b = last_lba[23:16];
               3'd2:    b = last_lba[15:8];
               3'd3:    b = last_lba[7:0];
               3'd6:    b = 8'h02;
               default: b = 8'h00;
            endcase
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### rtl/scr_req_if.sv
// Command channel of the SCSI command responder: handshake and decoded command word.
// Depends on nothing.
interface scr_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  command;
   logic [31:0] block_address;
   logic [15:0] block_count;
   logic [31:0] host_length;
   logic        direction_in;

   modport source (output valid, command, block_address, block_count, host_length,
                   direction_in, input ready);
   modport sink (input valid, command, block_address, block_count, host_length,
                 direction_in, output ready);
endinterface

### rtl/scr_rsp_if.sv
// Response channel of the SCSI command responder: handshake and result word.
// Depends on nothing.
interface scr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        data_valid;
   logic        last;
   logic        accepted;
   logic        stall_in;
   logic        stall_out;
   logic        send_status;
   logic [1:0]  transfer_kind;
   logic [40:0] start_offset;
   logic [24:0] transfer_bytes;
   logic [31:0] residue;

   modport source (output valid, data_byte, data_valid, last, accepted, stall_in, stall_out,
                   send_status, transfer_kind, start_offset, transfer_bytes, residue,
                   input ready);
   modport sink (input valid, data_byte, data_valid, last, accepted, stall_in, stall_out,
                 send_status, transfer_kind, start_offset, transfer_bytes, residue,
                 output ready);
endinterface

### rtl/scsi_command_responder.sv
// SCSI command responder top level: microcoded sequencer and its datapath.
// Depends on scr_pkg, scr_req_if and scr_rsp_if.
//
//   channel   direction  handshake               content
//   req       in         req.valid / req.ready   one decoded command block
//   rsp       out        rsp.valid / rsp.ready   response byte or transfer summary
//   csr       in         csr_we                  medium_sectors
//
// One command at a time. Data responses: decode, then one byte per cycle unless stalled.
// READ10: ROOM, CLAMP, RESID, EMIT; WRITE10: ENDCHK, WRSZ, RESID, EMIT; others: RESID, EMIT.
// Output register frees the sequencer unless rsp.ready stays low.
// Reset is synchronous; it clears the step counter, the output valid and medium_sectors.
module scsi_command_responder
   import scr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   scr_req_if.sink     req,
   scr_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   ctl_word_type cw;

   step_type     step_ff, step_in;
   logic [31:0]  medium_sectors_ff;
   cls_type      cls_ff, cls_in;
   logic [31:0]  lba_ff, lba_in;
   logic [15:0]  cnt_ff, cnt_in;
   logic [31:0]  host_ff, host_in;
   logic         dir_in_ff, dir_in_in;
   logic         len_ok_ff, len_ok_in;
   logic [40:0]  room_ff, room_in;
   logic         over_ff, over_in;
   logic         wr_stall_ff, wr_stall_in;
   logic [24:0]  bytes_ff, bytes_in;
   logic [31:0]  residue_ff, residue_in;
   logic [5:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_ff, rsp_in;

   logic         req_take;
   logic         out_free;
   logic         out_load;
   logic [40:0]  size;
   logic [40:0]  offset;
   logic [24:0]  length;
   logic [41:0]  end_sum;
   logic [5:0]   rlen;
   logic         run_last;
   logic         dir_ok;
   logic         xfer_ok;
   kind_type     kind;

   assign cw       = ucode(step_ff);
   assign req.ready = (cw.jmp == JMP_WAIT_REQ);
   assign req_take = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign out_load = out_free && (cw.op == OP_EMIT_RUN || cw.op == OP_EMIT_ONE);

   assign size     = {medium_sectors_ff, 9'd0};
   assign offset   = {lba_ff, 9'd0};
   assign length   = {cnt_ff, 9'd0};
   assign end_sum  = {1'b0, offset} + {17'd0, length};
   assign rlen     = run_len(cls_ff);
   assign run_last = (idx_ff == 6'(rlen - 6'd1));
   assign dir_ok   = (cls_ff == CLS_READ) ? dir_in_ff : !dir_in_ff;
   assign xfer_ok  = len_ok_ff && dir_ok;

   always_comb begin
      if (bytes_ff == '0) begin
         kind = KIND_NONE;
      end else if (cls_ff == CLS_READ) begin
         kind = KIND_READ;
      end else begin
         kind = KIND_WRITE;
      end
   end

   // sequencer
   always_comb begin
      step_in = step_ff;
      unique case (cw.jmp)
         JMP_WAIT_REQ: begin
            if (req_take) begin
               step_in = cw.target;
            end
         end
         JMP_NEXT: step_in = step_type'(step_ff + 4'd1);
         JMP_GOTO: step_in = cw.target;
         JMP_DISPATCH: begin
            unique case (cls_ff)
               CLS_INQUIRY, CLS_SENSE, CLS_MODE6,
               CLS_MODE10, CLS_RFC, CLS_RCAP: step_in = STEP_RUN;
               CLS_READ:                      step_in = STEP_ROOM;
               CLS_WRITE:                     step_in = STEP_ENDCHK;
               default:                       step_in = STEP_RESID;
            endcase
         end
         JMP_RUN: begin
            if (out_free && run_last) begin
               step_in = cw.target;
            end
         end
         JMP_EMIT: begin
            if (out_free) begin
               step_in = cw.target;
            end
         end
         default: step_in = STEP_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      cls_in       = cls_ff;
      lba_in       = lba_ff;
      cnt_in       = cnt_ff;
      host_in      = host_ff;
      dir_in_in    = dir_in_ff;
      len_ok_in    = len_ok_ff;
      room_in      = room_ff;
      over_in      = over_ff;
      wr_stall_in  = wr_stall_ff;
      bytes_in     = bytes_ff;
      residue_in   = residue_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      if (req_take) begin
         cls_in    = cmd_class(req.command);
         lba_in    = req.block_address;
         cnt_in    = req.block_count;
         host_in   = req.host_length;
         dir_in_in = req.direction_in;
      end

      unique case (cw.op)
         OP_DECODE: begin
            len_ok_in   = (host_ff == {7'd0, length});
            bytes_in    = '0;
            wr_stall_in = 1'b0;
            idx_in      = '0;
            residue_in  = (host_ff > {26'd0, rlen}) ? host_ff - {26'd0, rlen} : '0;
         end
         OP_ROOM: begin
            room_in = (size > offset) ? size - offset : '0;
         end
         OP_CLAMP: begin
            if (!xfer_ok) begin
               bytes_in = '0;
            end else if ({16'd0, length} < room_ff) begin
               bytes_in = length;
            end else begin
               bytes_in = room_ff[24:0];
            end
         end
         OP_ENDCHK: begin
            over_in = (end_sum > {1'b0, size});
         end
         OP_WRSZ: begin
            if (xfer_ok && length != '0) begin
               bytes_in    = over_ff ? 25'd512 : length;
               wr_stall_in = over_ff;
            end else begin
               bytes_in    = '0;
               wr_stall_in = 1'b0;
            end
         end
         OP_RESID: begin
            residue_in = (host_ff > {7'd0, bytes_ff}) ? host_ff - {7'd0, bytes_ff} : '0;
         end
         OP_EMIT_RUN: begin
            if (out_load) begin
               rsp_in               = '0;
               rsp_in.data_byte     = run_byte(cls_ff, idx_ff, medium_sectors_ff);
               rsp_in.data_valid    = 1'b1;
               rsp_in.last          = run_last;
               rsp_in.accepted      = 1'b1;
               rsp_in.transfer_kind = KIND_NONE;
               rsp_in.residue       = residue_ff;
               rsp_valid_in         = 1'b1;
               idx_in               = 6'(idx_ff + 6'd1);
            end
         end
         OP_EMIT_ONE: begin
            if (out_load) begin
               rsp_in               = '0;
               rsp_in.last          = 1'b1;
               rsp_in.accepted      = 1'b1;
               rsp_in.transfer_kind = kind;
               rsp_in.residue       = residue_ff;
               if (kind != KIND_NONE) begin
                  rsp_in.start_offset   = offset;
                  rsp_in.transfer_bytes = bytes_ff;
               end
               unique case (cls_ff)
                  CLS_READ, CLS_WRITE: begin
                     rsp_in.accepted    = dir_ok;
                     rsp_in.stall_in    = !len_ok_ff;
                     rsp_in.stall_out   = !len_ok_ff || wr_stall_ff;
                     rsp_in.send_status = !len_ok_ff;
                  end
                  CLS_VERIFY: begin
                     rsp_in.send_status = (host_ff == '0);
                     rsp_in.stall_out   = (host_ff != '0) && dir_in_ff;
                  end
                  CLS_UNKNOWN: begin
                     rsp_in.accepted    = 1'b0;
                     rsp_in.send_status = 1'b1;
                  end
                  default: begin
                     rsp_in.accepted = 1'b1;
                  end
               endcase
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff           <= STEP_IDLE;
         rsp_valid_ff      <= 1'b0;
         medium_sectors_ff <= '0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            medium_sectors_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cls_ff      <= cls_in;
      lba_ff      <= lba_in;
      cnt_ff      <= cnt_in;
      host_ff     <= host_in;
      dir_in_ff   <= dir_in_in;
      len_ok_ff   <= len_ok_in;
      room_ff     <= room_in;
      over_ff     <= over_in;
      wr_stall_ff <= wr_stall_in;
      bytes_ff    <= bytes_in;
      residue_ff  <= residue_in;
      idx_ff      <= idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.data_byte      = rsp_ff.data_byte;
   assign rsp.data_valid     = rsp_ff.data_valid;
   assign rsp.last           = rsp_ff.last;
   assign rsp.accepted       = rsp_ff.accepted;
   assign rsp.stall_in       = rsp_ff.stall_in;
   assign rsp.stall_out      = rsp_ff.stall_out;
   assign rsp.send_status    = rsp_ff.send_status;
   assign rsp.transfer_kind  = rsp_ff.transfer_kind;
   assign rsp.start_offset   = rsp_ff.start_offset;
   assign rsp.transfer_bytes = rsp_ff.transfer_bytes;
   assign rsp.residue        = rsp_ff.residue;

`ifndef SYNTHESIS
   a_take_decodes: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (step_ff == STEP_DECODE))
      else $error("accepted command did not advance to decode");

   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_in.last) |=> (step_ff == STEP_IDLE))
      else $error("sequencer not idle after last word");

   a_kind_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_in.transfer_kind != KIND_NONE) |-> (rsp_in.transfer_bytes != '0))
      else $error("transfer with zero bytes");

   a_data_no_xfer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.data_valid) |->
         (rsp_ff.transfer_kind == KIND_NONE && rsp_ff.accepted && !rsp_ff.send_status))
      else $error("data word carries transfer or status");

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (step_ff != STEP_IDLE) |-> !req.ready)
      else $error("command taken while busy");
`endif

endmodule

### dv/tb_scsi_command_responder.sv
// Testbench for scsi_command_responder: drives decoded command words, predicts every
// response word and checks them in order, with random idling on both channels.
// Depends on scr_pkg, scr_req_if, scr_rsp_if and the scsi_command_responder RTL.
module tb_scsi_command_responder
   import scr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_PER_PHASE = 31;

   typedef struct packed {
      logic [7:0]  command;
      logic [31:0] block_address;
      logic [15:0] block_count;
      logic [31:0] host_length;
      logic        direction_in;
   } cmd_word_type;

   localparam logic [7:0] INQ_BYTES [36] = '{
      8'h00, 8'h80, 8'h00, 8'h01, 8'h20, 8'h80, 8'h00, 8'h00,
      8'h46, 8'h44, 8'h49, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
      8'h75, 8'h45, 8'h5A, 8'h20, 8'h4D, 8'h53, 8'h20, 8'h44,
      8'h69, 8'h73, 8'h6B, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
      8'h31, 8'h2E, 8'h30, 8'h20
   };
   localparam logic [7:0] UNIT_ATTN_BYTES [18] = '{
      8'h70, 8'h00, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0A, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   class scsi_reply_tracker;
      rsp_word_type expected_replies[$];
      logic [31:0]  medium_sectors;
      int           commands;
      int           replies;
      int           mismatches;

      function new();
         medium_sectors = '0;
         commands = 0;
         replies = 0;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      function void queue_byte_run(logic [7:0] run[$], logic [31:0] host);
         rsp_word_type r;
         for (int k = 0; k < run.size(); k++) begin
            r = '0;
            r.data_byte = run[k];
            r.data_valid = 1'b1;
            r.last = (k == run.size() - 1);
            r.accepted = 1'b1;
            r.residue = (host > run.size()) ? host - run.size() : 32'd0;
            expected_replies.push_back(r);
         end
      endfunction

      function void note_command(cmd_word_type c);
         logic [63:0] offset;
         logic [63:0] length;
         logic [63:0] medium_bytes;
         logic [63:0] room;
         logic [63:0] moved;
         logic [31:0] last_lba;
         logic [7:0]  run[$];
         logic        is_read;
         logic        dir_ok;
         kind_type    kind;
         rsp_word_type r;
         commands++;
         offset = 64'(c.block_address) << SECTOR_SHIFT;
         length = 64'(c.block_count) << SECTOR_SHIFT;
         medium_bytes = 64'(medium_sectors) << SECTOR_SHIFT;
         last_lba = medium_sectors - 32'd1;
         moved = '0;
         kind = KIND_NONE;
         r = '0;
         r.last = 1'b1;
         r.accepted = 1'b1;
         case (c.command)
            OPC_INQUIRY: begin
               foreach (INQ_BYTES[i]) run.push_back(INQ_BYTES[i]);
               queue_byte_run(run, c.host_length);
               return;
            end
            OPC_SENSE: begin
               foreach (UNIT_ATTN_BYTES[i]) run.push_back(UNIT_ATTN_BYTES[i]);
               queue_byte_run(run, c.host_length);
               return;
            end
            OPC_MODE6: begin
               run = {8'h03, 8'h00, 8'h00, 8'h00};
               queue_byte_run(run, c.host_length);
               return;
            end
            OPC_MODE10: begin
               run = {8'h00, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
               queue_byte_run(run, c.host_length);
               return;
            end
            OPC_RFC: begin
               run = {8'h00, 8'h00, 8'h00, 8'h08,
                      medium_sectors[31:24], medium_sectors[23:16],
                      medium_sectors[15:8], medium_sectors[7:0],
                      8'h02, 8'h00, 8'h02, 8'h00};
               queue_byte_run(run, c.host_length);
               return;
            end
            OPC_RCAP: begin
               run = {last_lba[31:24], last_lba[23:16], last_lba[15:8], last_lba[7:0],
                      8'h00, 8'h00, 8'h02, 8'h00};
               queue_byte_run(run, c.host_length);
               return;
            end
            OPC_TEST_READY, OPC_REMOVAL: begin
            end
            OPC_READ10, OPC_WRITE10: begin
               is_read = (c.command == OPC_READ10);
               dir_ok = is_read ? c.direction_in : !c.direction_in;
               if (64'(c.host_length) != length) begin
                  r.stall_in = 1'b1;
                  r.stall_out = 1'b1;
                  r.send_status = 1'b1;
               end
               if (!dir_ok) r.accepted = 1'b0;
               if (64'(c.host_length) == length && dir_ok) begin
                  if (is_read) begin
                     room = (medium_bytes > offset) ? medium_bytes - offset : 64'd0;
                     moved = (length < room) ? length : room;
                     kind = KIND_READ;
                  end else if (length != 0) begin
                     if (offset + length > medium_bytes) begin
                        r.stall_out = 1'b1;
                        moved = 64'd512;
                     end else begin
                        moved = length;
                     end
                     kind = KIND_WRITE;
                  end
                  if (moved == 0) kind = KIND_NONE;
               end
            end
            OPC_VERIFY10: begin
               if (c.host_length == 0) r.send_status = 1'b1;
               else if (c.direction_in) r.stall_out = 1'b1;
            end
            default: begin
               r.accepted = 1'b0;
               r.send_status = 1'b1;
            end
         endcase
         r.transfer_kind = kind;
         if (kind != KIND_NONE) begin
            r.start_offset = offset[40:0];
            r.transfer_bytes = moved[24:0];
         end
         r.residue = (64'(c.host_length) > moved) ? c.host_length - moved[31:0] : 32'd0;
         expected_replies.push_back(r);
      endfunction

      function void check_reply(rsp_word_type got);
         rsp_word_type want;
         string diff;
         replies++;
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("reply %0d arrived with none expected: %p", replies, got);
            return;
         end
         want = expected_replies.pop_front();
         diff = "";
         if (got.data_byte !== want.data_byte) diff = {diff, " data_byte"};
         if (got.data_valid !== want.data_valid) diff = {diff, " data_valid"};
         if (got.last !== want.last) diff = {diff, " last"};
         if (got.accepted !== want.accepted) diff = {diff, " accepted"};
         if (got.stall_in !== want.stall_in) diff = {diff, " stall_in"};
         if (got.stall_out !== want.stall_out) diff = {diff, " stall_out"};
         if (got.send_status !== want.send_status) diff = {diff, " send_status"};
         if (got.transfer_kind !== want.transfer_kind) diff = {diff, " transfer_kind"};
         if (got.start_offset !== want.start_offset) diff = {diff, " start_offset"};
         if (got.transfer_bytes !== want.transfer_bytes) diff = {diff, " transfer_bytes"};
         if (got.residue !== want.residue) diff = {diff, " residue"};
         if (diff != "") begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("reply %0d differs in%s", replies, diff);
               $display("  expected %p", want);
               $display("  actual   %p", got);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;
   logic        calm;
   int          idle_cycles;
   int          sizes_used;
   scsi_reply_tracker book;

   scr_req_if req_if ();
   scr_rsp_if rsp_if ();

   scsi_command_responder u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic cmd_word_type make_command(logic [7:0] op, logic [31:0] lba,
                                                 logic [15:0] cnt, logic [31:0] host,
                                                 logic dir_in);
      cmd_word_type c;
      c.command = op;
      c.block_address = lba;
      c.block_count = cnt;
      c.host_length = host;
      c.direction_in = dir_in;
      return c;
   endfunction

   function automatic cmd_word_type random_command(logic [31:0] sectors);
      cmd_word_type c;
      int unsigned  pick;
      logic [31:0]  len;
      c.command = 8'($urandom);
      c.block_address = $urandom;
      c.block_count = 16'($urandom);
      c.host_length = $urandom;
      c.direction_in = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         c.command = (pick < 30) ? OPC_READ10 : OPC_WRITE10;
         if ($urandom_range(0, 15) != 0) c.block_count = 16'($urandom_range(0, 64));
         case ($urandom_range(0, 3))
            0: c.block_address = $urandom_range(0, sectors);
            1: c.block_address = sectors - $urandom_range(0, 70);
            2: c.block_address = $urandom_range(0, 16);
            default: begin
            end
         endcase
         len = 32'(c.block_count) << SECTOR_SHIFT;
         case ($urandom_range(0, 9))
            0: begin
            end
            1: c.host_length = len + $urandom_range(1, 600);
            default: c.host_length = len;
         endcase
         if ($urandom_range(0, 6) != 0) c.direction_in = (c.command == OPC_READ10);
      end else if (pick < 62) begin
         c.command = OPC_VERIFY10;
         if ($urandom_range(0, 3) == 0) c.host_length = '0;
      end else if (pick < 82) begin
         case ($urandom_range(0, 5))
            0: c.command = OPC_INQUIRY;
            1: c.command = OPC_SENSE;
            2: c.command = OPC_MODE6;
            3: c.command = OPC_MODE10;
            4: c.command = OPC_RFC;
            default: c.command = OPC_RCAP;
         endcase
         if ($urandom_range(0, 1) == 0) c.host_length = $urandom_range(0, 40);
      end else if (pick < 88) begin
         c.command = ($urandom_range(0, 1) == 0) ? OPC_TEST_READY : OPC_REMOVAL;
      end
      return c;
   endfunction

   task automatic send_command(input cmd_word_type c);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 14);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.command <= c.command;
      req_if.block_address <= c.block_address;
      req_if.block_count <= c.block_count;
      req_if.host_length <= c.host_length;
      req_if.direction_in <= c.direction_in;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      book.note_command(c);
      if ($urandom_range(0, 19) == 0) calm = ~calm;
   endtask

   task automatic drain_replies();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
   endtask

   task automatic write_sectors(input logic [31:0] value);
      drain_replies();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      book.medium_sectors = value;
      sizes_used++;
   endtask

   // hold ready low for a random stall before each reply word
   initial begin : reply_sink
      int unsigned stall;
      rsp_if.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 14);
         repeat (stall) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
      end
   end

   always @(posedge clock) begin : reply_monitor
      rsp_word_type got;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.data_byte = rsp_if.data_byte;
            got.data_valid = rsp_if.data_valid;
            got.last = rsp_if.last;
            got.accepted = rsp_if.accepted;
            got.stall_in = rsp_if.stall_in;
            got.stall_out = rsp_if.stall_out;
            got.send_status = rsp_if.send_status;
            got.transfer_kind = kind_type'(rsp_if.transfer_kind);
            got.start_offset = rsp_if.start_offset;
            got.transfer_bytes = rsp_if.transfer_bytes;
            got.residue = rsp_if.residue;
            book.check_reply(got);
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("no handshake for %0d cycles, %0d replies outstanding",
                     idle_cycles, book.pending());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [31:0] phase_sizes [5];
      book = new();
      calm = 1'b0;
      sizes_used = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.command = '0;
      req_if.block_address = '0;
      req_if.block_count = '0;
      req_if.host_length = '0;
      req_if.direction_in = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty medium
      write_sectors(32'd0);
      send_command(make_command(OPC_RCAP, '0, '0, 32'd8, 1'b1));
      send_command(make_command(OPC_RFC, '0, '0, 32'd12, 1'b1));
      send_command(make_command(OPC_INQUIRY, '0, '0, 32'd0, 1'b1));
      send_command(make_command(OPC_SENSE, '0, '0, 32'd100, 1'b1));
      send_command(make_command(OPC_MODE6, '1, '1, 32'd4, 1'b0));
      send_command(make_command(OPC_MODE10, '0, '0, '1, 1'b1));
      send_command(make_command(OPC_TEST_READY, '0, '0, 32'd0, 1'b0));
      send_command(make_command(OPC_REMOVAL, '0, '0, 32'd77, 1'b0));
      send_command(make_command(8'hFF, '1, '1, '1, 1'b1));
      send_command(make_command(8'h01, '0, '0, 32'd0, 1'b0));
      send_command(make_command(OPC_READ10, '0, 16'd1, 32'd512, 1'b1));
      send_command(make_command(OPC_WRITE10, 32'd5, 16'd1, 32'd512, 1'b0));

      // largest medium
      write_sectors('1);
      send_command(make_command(OPC_RCAP, '0, '0, 32'd8, 1'b1));
      send_command(make_command(OPC_RFC, '0, '0, 32'd12, 1'b1));
      send_command(make_command(OPC_READ10, '1, '1, 32'h01FF_FE00, 1'b1));
      send_command(make_command(OPC_READ10, '0, 16'd8, 32'd4096, 1'b1));
      send_command(make_command(OPC_READ10, '0, 16'd8, 32'd4000, 1'b0));
      send_command(make_command(OPC_READ10, '0, 16'd8, 32'd4000, 1'b1));
      send_command(make_command(OPC_WRITE10, '0, 16'd8, 32'd4096, 1'b1));
      send_command(make_command(OPC_WRITE10, 32'hFFFF_FFFE, 16'd2, 32'd1024, 1'b0));
      send_command(make_command(OPC_WRITE10, 32'hFFFF_FFFE, 16'd3, 32'd1536, 1'b0));
      send_command(make_command(OPC_WRITE10, 32'd7, '0, 32'd0, 1'b0));
      send_command(make_command(OPC_READ10, 32'd7, '0, 32'd0, 1'b1));
      send_command(make_command(OPC_VERIFY10, '0, '0, 32'd0, 1'b1));
      send_command(make_command(OPC_VERIFY10, '0, '0, 32'd100, 1'b1));
      send_command(make_command(OPC_VERIFY10, '0, '0, 32'd100, 1'b0));

      phase_sizes[0] = 32'd1;
      phase_sizes[1] = $urandom_range(100, 5000);
      phase_sizes[2] = $urandom;
      phase_sizes[3] = '1;
      phase_sizes[4] = 32'd0;
      foreach (phase_sizes[p]) begin
         write_sectors(phase_sizes[p]);
         repeat (RANDOM_PER_PHASE) send_command(random_command(phase_sizes[p]));
      end

      drain_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d commands over %0d medium sizes, %0d reply words checked",
               book.commands, sizes_used, book.replies);
      $display("%0d mismatches, %0d replies outstanding", book.mismatches, book.pending());
      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
